/* design/sobel_edge_magnitude_rgb_assert.svh */
// assertion macros shared by the sobel edge block
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define SEM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sobel edge assertion failed");
// checked at every edge, reset included
`define SEM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sobel edge assertion failed");
`else
`define SEM_ASSERT(lbl, prop)
`define SEM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* design/sem_pkg.sv */
package sem_pkg;

  // size limits and reset values
  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 1024;
  localparam int unsigned PixW       = 24;
  localparam int unsigned QueueDepth = 2;
  localparam logic [10:0] CfgSizeReset = 11'd1024;

  // register indexes
  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } sem_reg_e;

  // one classified item between front and back
  typedef struct packed {
    logic [PixW-1:0] px;
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic            col0;
    logic            emit;
    logic            fend;
  } sem_item_t;

  // front status seen by the top level
  typedef struct packed {
    logic push;
    logic s1_busy;
  } sem_front_stat_t;

  // partial square root state
  typedef struct packed {
    logic [9:0] rem;
    logic [7:0] root;
  } sem_sqrt_t;

  // one digit of the restoring square root
  function automatic sem_sqrt_t sqrt_step(sem_sqrt_t cur, logic [1:0] pair);
    logic [11:0] acc;
    logic [11:0] trial;
    sem_sqrt_t   nxt;
    acc   = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (acc >= trial) begin
      nxt.rem  = 10'(acc - trial);
      nxt.root = {cur.root[6:0], 1'b1};
    end else begin
      nxt.rem  = acc[9:0];
      nxt.root = {cur.root[6:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

/* design/sem_ram.sv */
module sem_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port, registered read returning the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sem_queue.sv */
module sem_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sem_pkg::sem_item_t  item_i,
  input  logic                pop_i,
  output sem_pkg::sem_item_t  item_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned AW = $clog2(sem_pkg::QueueDepth);

  sem_pkg::sem_item_t mem_q [sem_pkg::QueueDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(sem_pkg::QueueDepth));
  assign item_o  = mem_q[rp_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(1);
      if (pop_i)  rp_q <= rp_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

endmodule

/* design/sem_front.sv */
module sem_front #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MaxHeight
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [10:0]                  cfg_width_i,
  input  logic [10:0]                  cfg_height_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic                         op_i,
  input  logic [sem_pkg::PixW-1:0]     pix_i,
  input  logic                         full_i,
  output logic                         push_o,
  output sem_pkg::sem_item_t           item_o,
  output sem_pkg::sem_front_stat_t     stat_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned PW = sem_pkg::PixW;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] w_eff, col_w, col_inc;
  logic [RW-1:0] h_eff, row_inc;
  logic          accept, px_en, top_en, mid_en, col0, emit, fend;
  logic [PW-1:0] px;
  logic [PW-1:0] rd0, rd1;

  logic          s1_v_q, s1_col0_q, s1_emit_q, s1_fend_q;
  logic          s1_top_en_q, s1_mid_en_q, s1_bank_q;
  logic [PW-1:0] s1_px_q;

  // effective frame size
  always_comb begin
    if (cfg_width_i == '0) w_eff = WW'(1);
    else if (32'(cfg_width_i) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_width_i);
    if (cfg_height_i == '0) h_eff = RW'(1);
    else if (32'(cfg_height_i) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(cfg_height_i);
  end

  assign ready_o = !s1_v_q || !full_i;
  assign push_o  = s1_v_q && !full_i;
  assign accept  = valid_i && ready_o;

  // classify the word by its raster position
  always_comb begin
    col_w  = WW'(col_q);
    px_en  = !op_i && (row_q < h_eff);
    top_en = (row_q >= RW'(2)) && (row_q < h_eff + RW'(2));
    mid_en = (row_q >= RW'(1)) && (row_q < h_eff + RW'(1));
    col0   = (col_q == '0);
    emit   = col0 ? top_en : mid_en;
    fend   = emit && (col0 ? (row_q == h_eff + RW'(1))
                           : ((row_q == h_eff) && (col_w == w_eff)));
    px     = px_en ? pix_i : '0;
    col_inc = col_w + WW'(1);
    row_inc = row_q + RW'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = row_inc;
    end else begin
      col_d = CW'(col_inc);
      row_d = row_q;
    end
    if (fend || (row_d > h_eff + RW'(1))) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept)      s1_v_q <= 1'b1;
      else if (push_o) s1_v_q <= 1'b0;
    end
  end

  // item waiting for its line store words
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q     <= px;
      s1_col0_q   <= col0;
      s1_emit_q   <= emit;
      s1_fend_q   <= fend;
      s1_top_en_q <= top_en;
      s1_mid_en_q <= mid_en;
      s1_bank_q   <= row_q[0];
    end
  end

  // line store, one bank per row parity
  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (accept && !row_q[0]),
    .waddr_i (col_q),
    .wdata_i (px),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd0)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (accept && row_q[0]),
    .waddr_i (col_q),
    .wdata_i (px),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd1)
  );

  // top comes from the same parity bank, mid from the other
  always_comb begin
    item_o.px   = s1_px_q;
    item_o.top  = s1_top_en_q ? (s1_bank_q ? rd1 : rd0) : '0;
    item_o.mid  = s1_mid_en_q ? (s1_bank_q ? rd0 : rd1) : '0;
    item_o.col0 = s1_col0_q;
    item_o.emit = s1_emit_q;
    item_o.fend = s1_fend_q;
  end

  assign stat_o.push    = push_o;
  assign stat_o.s1_busy = s1_v_q;

endmodule

/* design/sem_back.sv */
module sem_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  sem_pkg::sem_item_t       item_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [sem_pkg::PixW-1:0] edge_o,
  output logic                     last_o
);

  localparam int unsigned PW = sem_pkg::PixW;

  logic en;
  logic [PW-1:0] win_q [9];
  logic [PW-1:0] tmp [9];
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];
  logic [9:0]  ax [3];
  logic [9:0]  ay [3];
  logic [20:0] sq [3];
  sem_pkg::sem_sqrt_t r3n [3];
  sem_pkg::sem_sqrt_t r4n [3];
  logic [7:0]  mag [3];

  logic v1_q, f1_q, v2_q, f2_q, v3_q, f3_q, v4_q, f4_q, out_v_q, last_q;
  logic [9:0]  ax1_q [3];
  logic [9:0]  ay1_q [3];
  logic        sat2_q [3];
  logic [15:0] s2_q [3];
  logic        sat3_q [3];
  logic [7:0]  lo3_q [3];
  sem_pkg::sem_sqrt_t r3_q [3];
  logic        sat4_q [3];
  sem_pkg::sem_sqrt_t r4_q [3];
  logic [PW-1:0] edge_q;

  function automatic logic signed [11:0] ch(logic [PW-1:0] p, int unsigned k);
    return 12'(signed'({1'b0, p[8*k +: 8]}));
  endfunction

  assign en    = !out_v_q || ready_i;
  assign pop_o = en && !empty_i;

  // shifted window with the new column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tmp[3*k]     = win_q[3*k + 1];
      tmp[3*k + 1] = win_q[3*k + 2];
    end
    tmp[2] = item_i.col0 ? '0 : item_i.top;
    tmp[5] = item_i.col0 ? '0 : item_i.mid;
    tmp[8] = item_i.col0 ? '0 : item_i.px;
  end

  // gradients per channel
  always_comb begin
    for (int unsigned k = 0; k < 3; k++) begin
      gx[k] = (ch(tmp[2], k) + 12'sd2 * ch(tmp[5], k) + ch(tmp[8], k))
            - (ch(tmp[0], k) + 12'sd2 * ch(tmp[3], k) + ch(tmp[6], k));
      gy[k] = (ch(tmp[6], k) + 12'sd2 * ch(tmp[7], k) + ch(tmp[8], k))
            - (ch(tmp[0], k) + 12'sd2 * ch(tmp[1], k) + ch(tmp[2], k));
      ax[k] = gx[k][11] ? 10'(-gx[k]) : 10'(gx[k]);
      ay[k] = gy[k][11] ? 10'(-gy[k]) : 10'(gy[k]);
    end
  end

  // window update on every popped word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (pop_o) begin
      if (item_i.col0) begin
        for (int k = 0; k < 9; k++) win_q[k] <= '0;
        win_q[2] <= item_i.top;
        win_q[5] <= item_i.mid;
        win_q[8] <= item_i.px;
      end else begin
        for (int k = 0; k < 9; k++) win_q[k] <= tmp[k];
      end
    end
  end

  // squares, then two halves of the root, then rounding
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq[k] = {11'b0, ax1_q[k]} * {11'b0, ax1_q[k]}
            + {11'b0, ay1_q[k]} * {11'b0, ay1_q[k]};
      r3n[k] = '0;
      for (int j = 0; j < 4; j++) begin
        r3n[k] = sem_pkg::sqrt_step(r3n[k], s2_q[k][15 - 2*j -: 2]);
      end
      r4n[k] = r3_q[k];
      for (int j = 0; j < 4; j++) begin
        r4n[k] = sem_pkg::sqrt_step(r4n[k], lo3_q[k][7 - 2*j -: 2]);
      end
      if (sat4_q[k]) mag[k] = 8'hff;
      else if (r4_q[k].rem > {2'b00, r4_q[k].root}) mag[k] = r4_q[k].root + 8'd1;
      else mag[k] = r4_q[k].root;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= pop_o && item_i.emit;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      out_v_q <= v4_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q   <= item_i.fend;
      f2_q   <= f1_q;
      f3_q   <= f2_q;
      f4_q   <= f3_q;
      last_q <= f4_q;
      for (int k = 0; k < 3; k++) begin
        ax1_q[k]  <= ax[k];
        ay1_q[k]  <= ay[k];
        sat2_q[k] <= sq[k] > 21'd65280;
        s2_q[k]   <= sq[k][15:0];
        sat3_q[k] <= sat2_q[k];
        lo3_q[k]  <= s2_q[k][7:0];
        r3_q[k]   <= r3n[k];
        sat4_q[k] <= sat3_q[k];
        r4_q[k]   <= r4n[k];
        edge_q[8*k +: 8] <= mag[k];
      end
    end
  end

  assign valid_o = out_v_q;
  assign edge_o  = edge_q;
  assign last_o  = last_q;

endmodule

/* design/sobel_edge_magnitude_rgb.sv */
// Sobel edge magnitude on an RGB raster stream: each channel is filtered with
// the 3x3 Sobel kernels (zero outside the frame) and gives
// min(255, round(sqrt(gx^2+gy^2))). One word per clock is accepted and one
// result per clock is delivered while the output side is ready; the front
// takes a word every cycle unless the queue is full, through two line store
// banks of MAX_WIDTH words; the back runs a five-stage pipeline (window and
// gradients, squares, two root halves, rounding) behind a two-entry queue.
// The result for a pixel leaves width+1 words later, so after each frame the
// host sends width+1 flush words (tuser set). frame_end rides on tlast.
// Line store needs no clearing after reset; unwritten rows are masked out.
`include "sobel_edge_magnitude_rgb_assert.svh"

module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MaxHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel_blue, pixel_green, pixel_red
  input  logic [0:0]  s_axis_tuser,  // op
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // edge_blue, edge_green, edge_red
  output logic        m_axis_tlast
);

  logic [10:0] cfg_w_q, cfg_h_q;
  logic        cfg_we;
  sem_pkg::sem_reg_e reg_sel;
  sem_pkg::sem_item_t fr_item, q_item;
  sem_pkg::sem_front_stat_t fr_stat;
  logic fr_push;
  logic q_full, q_empty, q_pop;

  // register file
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = sem_pkg::sem_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= sem_pkg::CfgSizeReset;
      cfg_h_q <= sem_pkg::CfgSizeReset;
    end else if (cfg_we) begin
      unique case (reg_sel)
        sem_pkg::RegWidth:  cfg_w_q <= pwdata[10:0];
        sem_pkg::RegHeight: cfg_h_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sem_pkg::RegWidth:  prdata = {21'b0, cfg_w_q};
      sem_pkg::RegHeight: prdata = {21'b0, cfg_h_q};
      default:            prdata = '0;
    endcase
  end

  // front: position, masks, line store
  sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (cfg_w_q),
    .cfg_height_i (cfg_h_q),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .op_i         (s_axis_tuser[0]),
    .pix_i        (s_axis_tdata),
    .full_i       (q_full),
    .push_o       (fr_push),
    .item_o       (fr_item),
    .stat_o       (fr_stat)
  );

  // queue between the halves
  sem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .item_i  (fr_item),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: window, gradients, magnitude
  sem_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .item_i  (q_item),
    .pop_o   (q_pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .edge_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  // checks
  `SEM_ASSERT(a_queue_no_overflow, fr_stat.push |-> !q_full)
  `SEM_ASSERT(a_stall_holds_queue, (m_axis_tvalid && !m_axis_tready) |-> !q_pop)
  `SEM_ASSERT(a_front_backpressure, (fr_stat.s1_busy && q_full) |-> !s_axis_tready)
  `SEM_ASSERT_ALWAYS(a_reset_no_output, !rst_ni |-> !m_axis_tvalid)

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomItems = 600;

  // one result word as the block should deliver it
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_word_t;

  // directed stimulus row, with a typed-in result where it is obvious
  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       typed;
    logic [7:0] mag;
    logic       last;
  } dir_row_t;

  localparam int DirRows = 26;
  // first frame: flat 3x3 white, every result saturates except the center
  // second frame: mixed colors, a flush inside the frame and a stray pixel
  // during the flush phase
  localparam dir_row_t DirTable [DirRows] = '{
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   1'b0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 1'b0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 1'b0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 1'b0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 1'b1},
    '{1'b0, 8'd255, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd0,   8'd0,   8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd128, 8'd1,   8'd254, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd7,   8'd200, 8'd90,  1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd255, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd170, 8'd85,  8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  sobel_edge_magnitude_rgb uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predictor state
  logic [23:0] row_mem [2*sem_pkg::MaxWidth];
  logic [23:0] win [9];
  int unsigned in_col;
  int unsigned in_row;
  logic [10:0] cfg_width;
  logic [10:0] cfg_height;

  edge_word_t  edge_q [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned frames_done;
  int unsigned burst_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, edge_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  function automatic int unsigned chan(logic [23:0] px, int sh);
    return (px >> sh) & 8'hff;
  endfunction

  // exact rounded, clamped magnitude
  function automatic logic [7:0] edge_mag(int gx, int gy);
    int unsigned s;
    int unsigned n;
    int unsigned t;
    s = gx * gx + gy * gy;
    if (s > 65280) return 8'd255;
    n = 0;
    for (int b = 128; b > 0; b = b >> 1) begin
      t = n | b;
      if (t * t <= s) n = t;
    end
    if (s >= n * n + n + 1) n++;
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  function automatic logic [7:0] sobel_chan(logic [23:0] w [9], int sh);
    int gx;
    int gy;
    gx = (chan(w[2], sh) + 2 * chan(w[5], sh) + chan(w[8], sh))
       - (chan(w[0], sh) + 2 * chan(w[3], sh) + chan(w[6], sh));
    gy = (chan(w[6], sh) + 2 * chan(w[7], sh) + chan(w[8], sh))
       - (chan(w[0], sh) + 2 * chan(w[1], sh) + chan(w[2], sh));
    return edge_mag(gx, gy);
  endfunction

  // advance the raster model by one accepted word
  task automatic predict_edge(input logic op, input logic [23:0] data,
                              output bit emit, output edge_word_t res);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned cc;
    int unsigned cur;
    int unsigned prv;
    int unsigned crow;
    int unsigned ccol;
    logic [23:0] px;
    logic [23:0] top;
    logic [23:0] mid;
    logic [23:0] nxt [9];
    bit fend;
    w = (cfg_width == 0) ? 1 :
        (cfg_width > sem_pkg::MaxWidth) ? sem_pkg::MaxWidth : cfg_width;
    h = (cfg_height == 0) ? 1 :
        (cfg_height > sem_pkg::MaxHeight) ? sem_pkg::MaxHeight : cfg_height;
    r = in_row;
    c = in_col;
    cc = (c < sem_pkg::MaxWidth) ? c : sem_pkg::MaxWidth - 1;
    cur = (r & 1) * sem_pkg::MaxWidth + cc;
    prv = ((r + 1) & 1) * sem_pkg::MaxWidth + cc;
    px = (op == 1'b0 && r < h) ? data : 24'd0;
    top = (r >= 2 && r - 2 < h) ? row_mem[cur] : 24'd0;
    mid = (r >= 1 && r - 1 < h) ? row_mem[prv] : 24'd0;
    row_mem[cur] = px;
    fend = 1'b0;
    crow = 0;
    ccol = 0;
    for (int k = 0; k < 3; k++) begin
      nxt[k*3] = win[k*3+1];
      nxt[k*3+1] = win[k*3+2];
    end
    // new row: window restarts with only the right column
    if (c == 0) begin
      nxt[2] = 24'd0;
      nxt[5] = 24'd0;
      nxt[8] = 24'd0;
      for (int k = 0; k < 9; k++) win[k] = 24'd0;
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      emit = (r >= 2);
      if (emit) begin
        crow = r - 2;
        ccol = w - 1;
      end
    end else begin
      nxt[2] = top;
      nxt[5] = mid;
      nxt[8] = px;
      win = nxt;
      emit = (r >= 1);
      if (emit) begin
        crow = r - 1;
        ccol = c - 1;
      end
    end
    if (emit && crow >= h) emit = 1'b0;
    res = '0;
    if (emit) begin
      fend = (crow == h - 1) && (ccol == w - 1);
      res.blue = sobel_chan(nxt, 0);
      res.green = sobel_chan(nxt, 8);
      res.red = sobel_chan(nxt, 16);
      res.last = fend;
    end
    if (c + 1 >= w) begin
      c = 0;
      r++;
    end else begin
      c++;
    end
    // frame wrap
    if (fend || r > h + 1) begin
      r = 0;
      c = 0;
      for (int k = 0; k < 9; k++) win[k] = 24'd0;
    end
    in_row = r;
    in_col = c;
    if (fend) frames_done++;
  endtask

  // push one word through the input side, with bursts and gaps
  task automatic send_word(input logic op, input logic [23:0] data,
                           input bit typed, input edge_word_t typed_res);
    int unsigned gap;
    bit emit;
    edge_word_t res;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    predict_edge(op, data, emit, res);
    if (typed) edge_q.push_back(typed_res);
    else if (emit) edge_q.push_back(res);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_rand(input logic op);
    send_word(op, {rand_chan(), rand_chan(), rand_chan()}, 1'b0, '0);
  endtask

  // wait for every pending result, then let the pipeline drain
  task automatic wait_idle();
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input sem_pkg::sem_reg_e idx, input logic [10:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {21'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // bring the raster position home, go idle, then resize
  task automatic set_size(input logic [10:0] w, input logic [10:0] h);
    while (in_row != 0 || in_col != 0) send_rand(1'b1);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    apb_write(sem_pkg::RegWidth, w);
    apb_write(sem_pkg::RegHeight, h);
    cfg_width = w;
    cfg_height = h;
  endtask

  // one frame of random content followed by its flush words
  task automatic send_frame(output int unsigned n);
    int unsigned w;
    int unsigned h;
    w = (cfg_width == 0) ? 1 :
        (cfg_width > sem_pkg::MaxWidth) ? sem_pkg::MaxWidth : cfg_width;
    h = (cfg_height == 0) ? 1 :
        (cfg_height > sem_pkg::MaxHeight) ? sem_pkg::MaxHeight : cfg_height;
    n = 0;
    for (int i = 0; i < w * h; i++) begin
      send_rand(($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0);
      n++;
    end
    for (int i = 0; i <= w; i++) begin
      send_rand(($urandom_range(0, 4) == 0) ? 1'b0 : 1'b1);
      n++;
    end
  endtask

  // receiver stalls in stretches of different character
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned mode;
      int unsigned len;
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 200);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    edge_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (edge_q.size() == 0) begin
        report_mismatch("unexpected result word", m_axis_tdata, 0);
      end else begin
        want = edge_q.pop_front();
        words_checked++;
        if (m_axis_tdata[7:0] !== want.blue)
          report_mismatch("edge_blue", m_axis_tdata[7:0], want.blue);
        if (m_axis_tdata[15:8] !== want.green)
          report_mismatch("edge_green", m_axis_tdata[15:8], want.green);
        if (m_axis_tdata[23:16] !== want.red)
          report_mismatch("edge_red", m_axis_tdata[23:16], want.red);
        if (m_axis_tlast !== want.last)
          report_mismatch("frame_end", m_axis_tlast, want.last);
      end
    end
  end

  // stimulus
  initial begin
    edge_word_t typed_res;
    int unsigned rand_items;
    int unsigned n;
    errors = 0;
    cycles = 0;
    words_sent = 0;
    words_checked = 0;
    frames_done = 0;
    burst_left = 0;
    rand_items = 0;
    in_col = 0;
    in_row = 0;
    cfg_width = sem_pkg::CfgSizeReset;
    cfg_height = sem_pkg::CfgSizeReset;
    for (int k = 0; k < 9; k++) win[k] = 24'd0;
    for (int k = 0; k < 2 * sem_pkg::MaxWidth; k++) row_mem[k] = 24'd0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames at 3x3
    set_size(11'd3, 11'd3);
    for (int i = 0; i < DirRows; i++) begin
      typed_res.red = DirTable[i].mag;
      typed_res.green = DirTable[i].mag;
      typed_res.blue = DirTable[i].mag;
      typed_res.last = DirTable[i].last;
      send_word(DirTable[i].op, {DirTable[i].red, DirTable[i].green, DirTable[i].blue},
                DirTable[i].typed, typed_res);
    end

    // small size extremes, including zero register values
    set_size(11'd1, 11'd1);
    send_frame(n);
    set_size(11'd0, 11'd5);
    send_frame(n);
    set_size(11'd6, 11'd0);
    send_frame(n);
    set_size(11'd1, 11'd7);
    send_frame(n);

    // random sizes, a few frames each
    while (rand_items < RandomItems) begin
      set_size(11'($urandom_range(1, 8)), 11'($urandom_range(1, 6)));
      repeat ($urandom_range(1, 3)) begin
        send_frame(n);
        rand_items += n;
      end
      // a few stray words between frames
      repeat ($urandom_range(0, 2)) begin
        send_rand(1'($urandom_range(0, 1)));
        rand_items++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    $display("%0d words in, %0d results checked, %0d frames over sizes 1x1 to 8x7",
             words_sent, words_checked, frames_done);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
